@@ sv/kvl_pkg.sv @@
// Shared types and constants of the key/value text lexer.
package kvl_pkg;

  // Byte classes produced by the front end
  typedef enum logic [2:0] {
    CL_SPACE,
    CL_HASH,
    CL_EQ,
    CL_LF,
    CL_NUL,
    CL_PRINT,
    CL_OTHER
  } cls_t;

  // Token kinds as seen on token_kind
  localparam logic [2:0] KIND_IDENT = 3'd0;
  localparam logic [2:0] KIND_SEP   = 3'd1;
  localparam logic [2:0] KIND_TERM  = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Queue depths (powers of two)
  localparam int CQ_DEPTH = 4;
  localparam int TQ_DEPTH = 4;

  // Head of the class queue as offered to the back end
  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_beat_t;

  // One result token
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

endpackage

@@ sv/kvl_front.sv @@
// Front end: classifies incoming text bytes and queues the classes.
module kvl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          text_byte,
  output kvl_pkg::cls_beat_t  head,
  input  logic                take
);

  localparam int AW = $clog2(kvl_pkg::CQ_DEPTH);
  localparam int CW = AW + 1;

  kvl_pkg::cls_t   mem [kvl_pkg::CQ_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   count;
  kvl_pkg::cls_t   cls_in;
  logic            wr;
  logic            rd;

  always_comb begin
    if (text_byte == kvl_pkg::CH_SPACE) begin
      cls_in = kvl_pkg::CL_SPACE;
    end else if (text_byte == kvl_pkg::CH_HASH) begin
      cls_in = kvl_pkg::CL_HASH;
    end else if (text_byte == kvl_pkg::CH_EQ) begin
      cls_in = kvl_pkg::CL_EQ;
    end else if (text_byte == kvl_pkg::CH_LF) begin
      cls_in = kvl_pkg::CL_LF;
    end else if (text_byte == kvl_pkg::CH_NUL) begin
      cls_in = kvl_pkg::CL_NUL;
    end else if (text_byte >= kvl_pkg::CH_BANG && text_byte <= kvl_pkg::CH_TILDE) begin
      cls_in = kvl_pkg::CL_PRINT;
    end else begin
      cls_in = kvl_pkg::CL_OTHER;
    end
  end

  assign full       = (count == CW'(kvl_pkg::CQ_DEPTH));
  assign wr         = push && !full;
  assign rd         = take && head.valid;
  assign head.valid = (count != '0);
  assign head.cls   = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= AW'(wptr + 1'b1);
      end
      if (rd) begin
        rptr <= AW'(rptr + 1'b1);
      end
      count <= CW'(count + CW'(wr) - CW'(rd));
    end
  end

endmodule

@@ sv/kvl_back.sv @@
// Back end: lexer state machine and the token queue it fills.
module kvl_back #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  kvl_pkg::cls_beat_t  head,
  output logic                take,
  input  logic                pop,
  output logic                empty,
  output logic [2:0]          token_kind,
  output logic [15:0]         token_start,
  output logic [15:0]         token_length,
  output logic                last_of_run
);

  localparam int AW = $clog2(kvl_pkg::TQ_DEPTH);
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    M_BLANK,
    M_COMMENT,
    M_IDENT
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] ident_start, ident_start_next;
  logic [15:0]            ident_length, ident_length_next;

  kvl_pkg::tok_t   mem [kvl_pkg::TQ_DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  kvl_pkg::tok_t   tok_a, tok_b, wr0_tok, wr1_tok;
  logic            emit_a, emit_b, relex, restart;
  logic [1:0]      nwr;
  logic            rd;
  logic [15:0]     pos16, start16;

  function automatic logic [15:0] clip16(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign pos16   = clip16(byte_offset);
  assign start16 = clip16(ident_start);

  // Room for two tokens is required before a class beat is taken
  assign take  = head.valid && (count <= CW'(kvl_pkg::TQ_DEPTH - 2));
  assign empty = (count == '0);
  assign rd    = pop && !empty;

  always_comb begin
    mode_next         = mode;
    ident_start_next  = ident_start;
    ident_length_next = ident_length;
    emit_a            = 1'b0;
    emit_b            = 1'b0;
    relex             = 1'b0;
    restart           = 1'b0;
    tok_a             = '{kind: kvl_pkg::KIND_IDENT, start: start16,
                          length: ident_length, last: 1'b0};
    tok_b             = '{kind: kvl_pkg::KIND_ERROR, start: pos16,
                          length: 16'd0, last: 1'b1};

    unique case (mode)
      M_IDENT: begin
        if (head.cls == kvl_pkg::CL_PRINT) begin
          if (ident_length != 16'hFFFF) begin
            ident_length_next = ident_length + 16'd1;
          end
        end else if (head.cls == kvl_pkg::CL_OTHER) begin
          emit_b  = 1'b1;
          restart = 1'b1;
        end else begin
          // identifier closed, the byte is lexed again from blank
          emit_a            = 1'b1;
          mode_next         = M_BLANK;
          ident_length_next = 16'd0;
          relex             = 1'b1;
        end
      end
      M_COMMENT: begin
        if (head.cls == kvl_pkg::CL_LF) begin
          mode_next = M_BLANK;
        end else if (head.cls == kvl_pkg::CL_NUL) begin
          emit_b       = 1'b1;
          tok_b.kind   = kvl_pkg::KIND_END;
          restart      = 1'b1;
        end
      end
      default: relex = 1'b1;
    endcase

    if (relex) begin
      unique case (head.cls)
        kvl_pkg::CL_SPACE: ;
        kvl_pkg::CL_HASH:  mode_next = M_COMMENT;
        kvl_pkg::CL_EQ: begin
          emit_b       = 1'b1;
          tok_b.kind   = kvl_pkg::KIND_SEP;
          tok_b.length = 16'd1;
        end
        kvl_pkg::CL_LF: begin
          emit_b       = 1'b1;
          tok_b.kind   = kvl_pkg::KIND_TERM;
          tok_b.length = 16'd1;
        end
        kvl_pkg::CL_NUL: begin
          emit_b     = 1'b1;
          tok_b.kind = kvl_pkg::KIND_END;
          restart    = 1'b1;
        end
        kvl_pkg::CL_PRINT: begin
          mode_next         = M_IDENT;
          ident_start_next  = byte_offset;
          ident_length_next = 16'd1;
        end
        default: begin
          emit_b  = 1'b1;
          restart = 1'b1;
        end
      endcase
    end

    if (restart) begin
      mode_next         = M_BLANK;
      byte_offset_next  = '0;
      ident_start_next  = '0;
      ident_length_next = 16'd0;
    end else if (byte_offset == '1) begin
      byte_offset_next  = byte_offset;
    end else begin
      byte_offset_next  = byte_offset + 1'b1;
    end
  end

  // Pack the tokens of this beat into consecutive queue slots
  always_comb begin
    wr1_tok = tok_b;
    if (emit_a) begin
      wr0_tok      = tok_a;
      wr0_tok.last = !emit_b;
    end else begin
      wr0_tok = tok_b;
    end
    if (!take) begin
      nwr = 2'd0;
    end else begin
      nwr = 2'(emit_a) + 2'(emit_b);
    end
  end

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) begin
      mem[wptr] <= wr0_tok;
    end
    if (nwr == 2'd2) begin
      mem[AW'(wptr + 1'b1)] <= wr1_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_BLANK;
      byte_offset  <= '0;
      ident_start  <= '0;
      ident_length <= 16'd0;
      wptr         <= '0;
      rptr         <= '0;
      count        <= '0;
    end else begin
      if (take) begin
        mode         <= mode_next;
        byte_offset  <= byte_offset_next;
        ident_start  <= ident_start_next;
        ident_length <= ident_length_next;
      end
      wptr <= AW'(wptr + AW'(nwr));
      if (rd) begin
        rptr <= AW'(rptr + 1'b1);
      end
      count <= CW'(count + CW'(nwr) - CW'(rd));
    end
  end

  assign token_kind   = mem[rptr].kind;
  assign token_start  = mem[rptr].start;
  assign token_length = mem[rptr].length;
  assign last_of_run  = mem[rptr].last;

  a_tq_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(kvl_pkg::TQ_DEPTH))
    else $error("token queue overfilled");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (take && restart) |=> (byte_offset == '0 && mode == M_BLANK))
    else $error("end or error did not clear lexer state");

  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    (mode == M_IDENT) |-> (ident_length != 16'd0))
    else $error("identifier mode with zero length");

  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    (mode != M_IDENT) |-> (ident_length == 16'd0))
    else $error("stale identifier length outside identifier mode");

  a_pair_room: assert property (@(posedge clk) disable iff (rst)
    (nwr == 2'd2) |-> (count <= CW'(kvl_pkg::TQ_DEPTH - 2)))
    else $error("two tokens written without room");

endmodule

@@ sv/key_value_text_lexer_top.sv @@
// Top level of the key/value text lexer: front classifier plus back lexer.
//
// Text bytes go in through push/full, one beat per byte, and tokens come out
// through empty/pop in byte order. While full is low the block takes one byte
// per clock: the front end classifies each byte into a four-entry queue, and
// the back end runs the lexer state machine on one queued byte per cycle when
// it is not stalled, writing up to two tokens into a four-entry token queue.
// The tokens of a byte pass through the class queue and then the token queue
// before they reach the result ports. A byte that closes an identifier can
// give two tokens, so the sustained rate is bounded by the single token read
// port: one token per pop cycle. The back end stalls only while fewer than two
// token slots are free. No clearing pass follows reset; the block accepts
// bytes from the first cycle after rst falls. Offsets count from zero after
// reset and after every end-of-input or error token, saturate at
// 2^OFFSET_BITS-1, and are reported clipped to 16 bits.
module key_value_text_lexer_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  // class beat from the front queue head, and the back end's take strobe
  kvl_pkg::cls_beat_t head;
  logic               take;

  kvl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .text_byte (text_byte),
    .head      (head),
    .take      (take)
  );

  kvl_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .take         (take),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the key/value text lexer.
module tb;

  localparam int OFFSET_BITS = 16;
  // Worst run: ~1250 bytes under the longest sender gaps or the heaviest pop
  // pattern, plus two long holds.
  // This is several times that.
  localparam int LIMIT = 100_000;
  // Tokens of a byte pass through the class queue and the token queue before they can be popped.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 1200;

  typedef enum logic [1:0] {
    LM_BLANK,
    LM_COMMENT,
    LM_IDENT
  } lex_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  key_value_text_lexer_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (token_kind),
    .token_start (token_start),
    .token_length(token_length),
    .last_of_run (last_of_run)
  );

  // Text still to be sent, and tokens the lexer owes us, oldest first.
  logic [7:0]    text_queue[$];
  kvl_pkg::tok_t token_queue[$];

  int errors = 0;
  int tokens_seen = 0;
  int bytes_in = 0;
  int cycle_count = 0;

  // Our own copy of the lexer state.
  lex_mode_t              lex_mode = LM_BLANK;
  logic [OFFSET_BITS-1:0] byte_pos = '0;
  logic [OFFSET_BITS-1:0] ident_pos = '0;
  logic [15:0]            ident_len = '0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Start and length are reported clipped to 16 bits.
  function automatic kvl_pkg::tok_t make_tok(logic [2:0] kind, longint unsigned start,
                                             longint unsigned len);
    kvl_pkg::tok_t t;
    t.kind   = kind;
    t.start  = (start > 64'hFFFF) ? 16'hFFFF : start[15:0];
    t.length = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
    t.last   = 1'b0;
    return t;
  endfunction

  // Advance the lexer state by one byte and queue the tokens it gives.
  task automatic lex_byte(input logic [7:0] c);
    logic [OFFSET_BITS-1:0] pos;
    kvl_pkg::tok_t toks[$];
    bit relex;
    bit restart;
    pos = byte_pos;
    relex = 1'b0;
    restart = 1'b0;
    case (lex_mode)
      LM_IDENT: begin
        if (c == kvl_pkg::CH_SPACE || c == kvl_pkg::CH_LF || c == kvl_pkg::CH_NUL ||
            c == kvl_pkg::CH_EQ || c == kvl_pkg::CH_HASH) begin
          // identifier closes, then the same byte goes through blank mode
          toks.insert(toks.size(), make_tok(kvl_pkg::KIND_IDENT, ident_pos, ident_len));
          lex_mode = LM_BLANK;
          ident_len = '0;
          relex = 1'b1;
        end else if (c >= kvl_pkg::CH_BANG && c <= kvl_pkg::CH_TILDE) begin
          if (ident_len != 16'hFFFF) ident_len++;
        end else begin
          // bad byte inside an identifier: the identifier is dropped
          toks.insert(toks.size(), make_tok(kvl_pkg::KIND_ERROR, pos, 0));
          restart = 1'b1;
        end
      end
      LM_COMMENT: begin
        if (c == kvl_pkg::CH_LF) begin
          lex_mode = LM_BLANK;  // linefeed swallowed
        end else if (c == kvl_pkg::CH_NUL) begin
          toks.insert(toks.size(), make_tok(kvl_pkg::KIND_END, pos, 0));
          restart = 1'b1;
        end
      end
      default: relex = 1'b1;
    endcase

    if (relex) begin
      case (c)
        kvl_pkg::CH_SPACE: begin end
        kvl_pkg::CH_HASH:  lex_mode = LM_COMMENT;
        kvl_pkg::CH_EQ:    toks.insert(toks.size(), make_tok(kvl_pkg::KIND_SEP, pos, 1));
        kvl_pkg::CH_LF:    toks.insert(toks.size(), make_tok(kvl_pkg::KIND_TERM, pos, 1));
        kvl_pkg::CH_NUL: begin
          toks.insert(toks.size(), make_tok(kvl_pkg::KIND_END, pos, 0));
          restart = 1'b1;
        end
        default: begin
          if (c >= kvl_pkg::CH_BANG && c <= kvl_pkg::CH_TILDE) begin
            lex_mode = LM_IDENT;
            ident_pos = pos;
            ident_len = 16'd1;
          end else begin
            toks.insert(toks.size(), make_tok(kvl_pkg::KIND_ERROR, pos, 0));
            restart = 1'b1;
          end
        end
      endcase
    end

    if (restart) begin
      lex_mode = LM_BLANK;
      byte_pos = '0;
      ident_pos = '0;
      ident_len = '0;
    end else if (byte_pos != '1) begin
      byte_pos++;  // saturates
    end

    if (toks.size() != 0) toks[toks.size()-1].last = 1'b1;
    foreach (toks[i]) token_queue.insert(token_queue.size(), toks[i]);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch on token %0d: %s got %0d want %0d", tokens_seen, what, got, want);
    errors++;
  endtask

  // ---- text builders --------------------------------------------------

  task automatic queue_byte(logic [7:0] c);
    text_queue.insert(text_queue.size(), c);
  endtask

  // Identifier body byte: printable, but not one that would close it.
  function automatic logic [7:0] ident_char();
    logic [7:0] c;
    do c = 8'($urandom_range(kvl_pkg::CH_BANG, kvl_pkg::CH_TILDE));
    while (c == kvl_pkg::CH_HASH || c == kvl_pkg::CH_EQ);
    return c;
  endfunction

  task automatic add_ident(int n);
    repeat (n) queue_byte(ident_char());
  endtask

  task automatic add_spaces(int n);
    repeat (n) queue_byte(kvl_pkg::CH_SPACE);
  endtask

  // Comment body: anything but linefeed and NUL, then the closing linefeed.
  task automatic add_comment(int n);
    logic [7:0] c;
    queue_byte(kvl_pkg::CH_HASH);
    repeat (n) begin
      do c = 8'($urandom_range(1, 255)); while (c == kvl_pkg::CH_LF);
      queue_byte(c);
    end
    queue_byte(kvl_pkg::CH_LF);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // ---- stimulus -------------------------------------------------------

  initial begin
    int pick;
    int target;

    // Directed part. Plain key/value line: identifier closed by space and by
    // linefeed, separator, skipped spaces.
    add_text("a =b\n");
    // Comment line: its linefeed gives no token.
    add_text("#c\n");
    // Identifier closed by '=' and by '#'; '~' and '!' are identifier bytes;
    // a high byte inside a comment is ignored.
    add_text("k=~!#");
    queue_byte(8'h80);
    queue_byte(kvl_pkg::CH_LF);
    // Tab inside an identifier: error, identifier dropped.
    add_text("z");
    queue_byte(8'h09);
    // Byte above '~' in blank mode: error.
    queue_byte(8'hFF);
    // NUL closes an identifier: identifier then end of input.
    add_text("q");
    queue_byte(kvl_pkg::CH_NUL);
    // NUL inside a comment, DEL in blank mode, NUL in blank mode.
    queue_byte(kvl_pkg::CH_HASH);
    queue_byte(kvl_pkg::CH_NUL);
    queue_byte(8'h7F);
    queue_byte(kvl_pkg::CH_NUL);

    // Random documents: mostly well-formed lines with random content, plus
    // noise and broken identifiers.
    target = text_queue.size() + RANDOM_BYTES;
    while (text_queue.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick <= 11) begin
        add_spaces($urandom_range(0, 2));
        add_ident($urandom_range(1, 8));
        add_spaces($urandom_range(0, 2));
        queue_byte(kvl_pkg::CH_EQ);
        add_spaces($urandom_range(0, 1));
        if ($urandom_range(0, 4) != 0) add_ident($urandom_range(1, 10));
        if ($urandom_range(0, 3) == 0) add_comment($urandom_range(0, 6));
        else queue_byte(kvl_pkg::CH_LF);
      end else if (pick <= 13) begin
        add_comment($urandom_range(0, 8));
      end else if (pick == 14) begin
        queue_byte(kvl_pkg::CH_LF);
      end else if (pick <= 16) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      end else if (pick == 17) begin
        add_ident($urandom_range(1, 6));
        queue_byte(8'($urandom_range(0, 255)));
      end else begin
        queue_byte(kvl_pkg::CH_NUL);
      end
    end

    // Counting starts over after the end token.
    queue_byte(kvl_pkg::CH_NUL);
    add_text("a=b\n");
    queue_byte(kvl_pkg::CH_NUL);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is taken and every token is back.
    do @(negedge clk);
    while (text_queue.size() != 0 || push || token_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && token_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  // ---- sender: bursts of beats with random gaps -----------------------

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    logic       nxt_push;
    logic [7:0] nxt_byte;
    if (rst) begin
      push <= 1'b0;
    end else begin
      nxt_push = push;
      nxt_byte = text_byte;
      if (push && !full) begin
        lex_byte(text_byte);
        void'(text_queue.pop_front());
        bytes_in++;
        nxt_push = 1'b0;
      end
      // A beat refused by full stays on the port unchanged.
      if (!nxt_push) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (text_queue.size() != 0) begin
          nxt_push = 1'b1;
          nxt_byte = text_queue[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
      push <= nxt_push;
      text_byte <= nxt_byte;
    end
  end

  // ---- receiver: pop pattern, plus long hold-offs to fill the block ----

  int hold_left = 0;
  int holds_done = 0;
  int win_left = 0;
  int pop_pat = 0;
  int pop_phase = 0;

  always @(posedge clk) begin : receive
    logic nxt_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      nxt_pop = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
      end else if (holds_done < 2 && bytes_in >= 300 + 500 * holds_done) begin
        // Long stall while the sender keeps pushing: both queues fill
        // and full must rise.
        hold_left = 250;
        holds_done++;
      end else begin
        if (win_left == 0) begin
          pop_pat = $urandom_range(0, 3);
          win_left = $urandom_range(10, 80);
        end else begin
          win_left--;
        end
        pop_phase++;
        case (pop_pat)
          0: nxt_pop = 1'b1;                          // no stalls
          1: nxt_pop = ($urandom_range(0, 3) != 0);   // light
          2: nxt_pop = ($urandom_range(0, 3) == 0);   // heavy
          default: nxt_pop = (pop_phase % 3 == 0);    // periodic
        endcase
      end
      pop <= nxt_pop;
    end
  end

  // ---- monitor: compare each popped token with the oldest expected ----

  always @(posedge clk) begin : monitor
    kvl_pkg::tok_t want;
    if (!rst && pop && !empty) begin
      if (token_queue.size() == 0) begin
        report("token kind with nothing expected", token_kind, -1);
      end else begin
        want = token_queue.pop_front();
        if (token_kind != want.kind) report("token_kind", token_kind, want.kind);
        if (token_start != want.start) report("token_start", token_start, want.start);
        if (token_length != want.length) report("token_length", token_length, want.length);
        if (last_of_run != want.last) report("last_of_run", last_of_run, want.last);
      end
      tokens_seen++;
    end
  end

endmodule
